// ===== src/pjdc_pkg.sv =====
package pjdc_pkg;

	// sign nibble written on encode and recognised as "no low digit" on decode
	localparam logic [3:0] SIGN_NIBBLE = 4'hF;
	localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;
	localparam logic [3:0] FEBRUARY = 4'd1;

	typedef struct packed {
		logic       mode;
		logic [7:0] packed_year;
		logic [7:0] packed_day_high;
		logic [7:0] packed_day_low;
		logic       century_sel;
		logic [7:0] years_since_1900;
		logic [3:0] month_index;
		logic [4:0] day_of_month;
	} item_t;

	typedef struct packed {
		logic [8:0] out_years_since_1900;
		logic [3:0] out_month;
		logic [4:0] out_day;
		logic       out_century;
		logic [7:0] out_packed_year;
		logic [7:0] out_packed_day_high;
		logic [7:0] out_packed_day_low;
	} result_t;

	// 4/100/400 rule on 1900 + ys; within range only 1900 and 2100 drop out
	function automatic logic is_leap(input logic [8:0] ys);
		return (ys[1:0] == 2'b00) && (ys != 9'd0) && (ys != 9'd200);
	endfunction

	// days in the months before month m (m = 12 gives the year length)
	function automatic logic [8:0] days_before(input logic [3:0] m, input logic leap);
		logic [8:0] d;
		case (m)
			4'd0: d = 9'd0;
			4'd1: d = 9'd31;
			4'd2: d = 9'd59;
			4'd3: d = 9'd90;
			4'd4: d = 9'd120;
			4'd5: d = 9'd151;
			4'd6: d = 9'd181;
			4'd7: d = 9'd212;
			4'd8: d = 9'd243;
			4'd9: d = 9'd273;
			4'd10: d = 9'd304;
			4'd11: d = 9'd334;
			default: d = 9'd365;
		endcase
		if (leap && (m > FEBRUARY))
			d = d + 9'd1;
		return d;
	endfunction

	// divide by ten through the reciprocal 205/2048, exact below 1029
	function automatic logic [5:0] div10(input logic [8:0] v);
		logic [16:0] p;
		p = 17'(v) * 17'd205;
		return p[16:11];
	endfunction

endpackage

// ===== src/pjdc_decode.sv =====
module pjdc_decode (
	input  pjdc_pkg::item_t   item,
	output pjdc_pkg::result_t result
);

	function automatic logic [7:0] unpack_byte(input logic [7:0] b);
		if (b[3:0] == pjdc_pkg::SIGN_NIBBLE)
			return {4'd0, b[7:4]};
		return 8'({b[7:4], 3'b000}) + 8'({b[7:4], 1'b0}) + 8'(b[3:0]);
	endfunction

	logic [7:0]  ydig;
	logic [7:0]  tens;
	logic [7:0]  ones;
	logic [8:0]  ysince;
	logic [10:0] ord;
	logic        leap;
	logic        in_year;
	logic [3:0]  mon;
	logic [10:0] day_full;

	always_comb begin
		ydig = unpack_byte(item.packed_year);
		tens = unpack_byte(item.packed_day_high);
		ones = unpack_byte(item.packed_day_low);
		ysince = 9'(ydig) + (item.century_sel ? 9'd100 : 9'd0);
		ord = 11'({tens, 3'b000}) + 11'({tens, 1'b0}) + 11'(ones);
		leap = pjdc_pkg::is_leap(ysince);
		in_year = (ord != 11'd0) &&
			(ord <= 11'(pjdc_pkg::days_before(pjdc_pkg::MONTHS_PER_YEAR, leap)));
		// month boundaries are increasing, so the last one passed wins
		mon = 4'd0;
		for (int m = 1; m < 12; m++) begin
			if (ord > 11'(pjdc_pkg::days_before(4'(m), leap)))
				mon = 4'(m);
		end
		day_full = ord - 11'(pjdc_pkg::days_before(mon, leap));

		result = '0;
		result.out_years_since_1900 = ysince;
		result.out_month = in_year ? mon : 4'd0;
		result.out_day = in_year ? day_full[4:0] : 5'd0;
	end

endmodule

// ===== src/pjdc_encode.sv =====
module pjdc_encode (
	input  pjdc_pkg::item_t   item,
	output pjdc_pkg::result_t result
);

	logic       leap;
	logic [3:0] lim;
	logic [8:0] ord;
	logic [5:0] ord_q;
	logic [8:0] ord_r;
	logic [5:0] q_hi;
	logic [8:0] q_lo;
	logic [7:0] ymod;
	logic [5:0] y_hi;
	logic [8:0] y_lo;

	always_comb begin
		leap = pjdc_pkg::is_leap(9'(item.years_since_1900));
		lim = (item.month_index > pjdc_pkg::MONTHS_PER_YEAR) ?
			pjdc_pkg::MONTHS_PER_YEAR : item.month_index;
		ord = pjdc_pkg::days_before(lim, leap) + 9'(item.day_of_month);

		ord_q = pjdc_pkg::div10(ord);
		ord_r = ord - 9'(ord_q) * 9'd10;
		q_hi = pjdc_pkg::div10(9'(ord_q));
		q_lo = 9'(ord_q) - 9'(q_hi) * 9'd10;

		if (item.years_since_1900 >= 8'd200)
			ymod = item.years_since_1900 - 8'd200;
		else if (item.years_since_1900 >= 8'd100)
			ymod = item.years_since_1900 - 8'd100;
		else
			ymod = item.years_since_1900;
		y_hi = pjdc_pkg::div10(9'(ymod));
		y_lo = 9'(ymod) - 9'(y_hi) * 9'd10;

		result = '0;
		result.out_century = (item.years_since_1900 >= 8'd100);
		result.out_packed_year = {y_hi[3:0], y_lo[3:0]};
		result.out_packed_day_high = {q_hi[3:0], q_lo[3:0]};
		result.out_packed_day_low = {ord_r[3:0], pjdc_pkg::SIGN_NIBBLE};
	end

endmodule

// ===== src/packed_julian_date_converter.sv =====
// packed julian date converter
//
// command channel: drive item and raise start; a transaction is taken at
// each rising edge where start is high and busy is low. busy never rises,
// so a new transaction may be issued on every cycle.
// item.mode picks the direction: 0 decodes the packed YY/DD/DS bytes into
// years since 1900, month and day; 1 encodes a calendar date into the packed
// bytes with an F sign nibble plus the century bit. fields of the other
// direction come back as zero.
// result channel: done is high for exactly one cycle with result valid in
// that cycle; the receiver cannot stall, so every result must be taken then.
// flow: the transaction is captured in the input register at its accept
// edge, then the converted value lands in the result register, whose
// valid flag drives done directly. throughput is one transaction per
// cycle, set by the single combinational pass between the two registers.
// reset: arst_n clears the valid flags at once, so no done appears after
// reset until a new transaction is taken; payload registers are not reset.
module packed_julian_date_converter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pjdc_pkg::item_t   item,
	output logic              done,
	output pjdc_pkg::result_t result
);

	pjdc_pkg::item_t   item_s1;
	logic              valid_s1;
	pjdc_pkg::result_t dec_res;
	pjdc_pkg::result_t enc_res;
	pjdc_pkg::result_t result_s2;
	logic              valid_s2;

	// nothing here ever has to hold a transaction back
	assign busy = 1'b0;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= item;
		end
	end

	// both directions are worked out side by side, mode picks one
	pjdc_decode u_decode (
		.item   (item_s1),
		.result (dec_res)
	);

	pjdc_encode u_encode (
		.item   (item_s1),
		.result (enc_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_s2 <= item_s1.mode ? enc_res : dec_res;
		end
	end

	assign done = valid_s2;
	assign result = result_s2;

`ifndef SYNTH
	// every captured transaction yields a result on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n) valid_s1 |=> done)
		else $error("captured transaction produced no result");

	// a result belongs to one direction only
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.out_packed_day_low == 8'h00 ||
			result.out_years_since_1900 == 9'd0))
		else $error("result mixes decode and encode fields");

	// decoded month stays within the year
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.out_month <= 4'd11)
		else $error("month out of range");

	// a zero day only comes with month zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.out_day == 5'd0) |-> result.out_month == 4'd0)
		else $error("zero day with non-zero month");
`endif

endmodule
